// ===== rtl/core/jptc_pkg.sv =====
package jptc_pkg;

	// Field and register widths.
	localparam int FREQ_W     = 29;
	localparam int SAMPLE_W   = 8;
	localparam int PRE_W      = 3;
	localparam int PERIOD_W   = 16;
	localparam int DUTY_W     = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int PRESS_W    = 3;
	localparam int HZ_W       = 13;
	localparam int STEP_W     = 4;
	localparam int ZSTEP_W    = 14;
	localparam int OSCALE_W   = 11;
	localparam int INC_W      = 25;
	localparam int CLOCK_W    = 25;

	// Shared divider widths.
	localparam int DIVIDEND_W = CLOCK_W;
	localparam int DIVISOR_W  = HZ_W;

	// Whole hertz: 100000 is 32 times 3125, so the frequency is shifted down by five
	// and multiplied by the rounded-up reciprocal of 3125 scaled by 2^36. The result
	// is exact for every 24-bit shifted value.
	localparam int HZ_SHIFT    = 5;
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 36;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_FLOOR   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_CEILING = 1'd1;

	// Reset values and fixed constants.
	localparam logic [FREQ_W-1:0]    FREQ_RESET  = 29'd250000000;
	localparam logic [FREQ_W-1:0]    FLOOR_RESET = 29'd10000000;
	localparam logic [FREQ_W-1:0]    CEIL_RESET  = 29'd500000000;
	localparam logic [RECIP_W-1:0]   HZ_RECIP    = 25'd21990233;
	localparam logic [CLOCK_W-1:0]   CLOCK_HZ    = 25'd24000000;

	// Microcode.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_TAKE,
		OP_STEP,
		OP_CLAMP,
		OP_DIV_GO,
		OP_DIV_WAIT,
		OP_HZ,
		OP_PRE,
		OP_EMIT
	} op_t;

	typedef enum logic {
		A_CLOCK,
		A_SHIFTED
	} a_sel_t;

	typedef struct packed {
		op_t               op;
		a_sel_t            a_sel;
		logic              jump;
		logic [STEP_W-1:0] target;
	} ctl_word_t;

	function automatic ctl_word_t rom_word(input logic [STEP_W-1:0] step);
		ctl_word_t w;
		w = '{op: OP_NOP, a_sel: A_CLOCK, jump: 1'b0, target: '0};
		case (step)
			4'd0: w.op = OP_TAKE;
			4'd1: w.op = OP_STEP;
			4'd2: w.op = OP_CLAMP;
			4'd3: w.op = OP_HZ;
			4'd4: begin
				w.op    = OP_DIV_GO;
				w.a_sel = A_CLOCK;
			end
			4'd5: w.op = OP_DIV_WAIT;
			4'd6: w.op = OP_PRE;
			4'd7: begin
				w.op    = OP_DIV_GO;
				w.a_sel = A_SHIFTED;
			end
			4'd8: w.op = OP_DIV_WAIT;
			4'd9: begin
				w.op     = OP_EMIT;
				w.jump   = 1'b1;
				w.target = '0;
			end
			default: begin
				w.op     = OP_NOP;
				w.jump   = 1'b1;
				w.target = '0;
			end
		endcase
		return w;
	endfunction

	// Signed frequency step of the joystick zone. Thresholds are on the raw
	// sample, which is the offset from center plus 128.
	function automatic logic signed [ZSTEP_W-1:0] zone_step(input logic [SAMPLE_W-1:0] s);
		logic signed [ZSTEP_W-1:0] r;
		if (s >= 8'd238)      r = 14'sd5000;
		else if (s >= 8'd218) r = 14'sd2500;
		else if (s >= 8'd198) r = 14'sd1250;
		else if (s >= 8'd178) r = 14'sd625;
		else if (s >= 8'd158) r = 14'sd300;
		else if (s >= 8'd98)  r = 14'sd0;
		else if (s >= 8'd78)  r = -14'sd300;
		else if (s >= 8'd58)  r = -14'sd625;
		else if (s >= 8'd38)  r = -14'sd1250;
		else if (s >= 8'd18)  r = -14'sd2500;
		else                  r = -14'sd5000;
		return r;
	endfunction

	// Octave of the frequency times 100. A whole-hertz value above N is the
	// same as a raw frequency of at least (N + 1) * 100000.
	function automatic logic [OSCALE_W-1:0] octave_scale(input logic [FREQ_W-1:0] f);
		logic [OSCALE_W-1:0] r;
		if (f >= 29'd410100000)     r = 11'd800;
		else if (f >= 29'd207100000) r = 11'd700;
		else if (f >= 29'd104100000) r = 11'd600;
		else if (f >= 29'd52100000)  r = 11'd500;
		else if (f >= 29'd26100000)  r = 11'd400;
		else if (f >= 29'd13100000)  r = 11'd300;
		else if (f >= 29'd8100000)   r = 11'd200;
		else                         r = 11'd0;
		return r;
	endfunction

endpackage

// ===== rtl/core/jptc_div.sv =====
module jptc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [jptc_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [jptc_pkg::DIVISOR_W-1:0]   divisor,
	output logic                             busy,
	output logic [jptc_pkg::DIVIDEND_W-1:0]  quotient
);
	import jptc_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);
	localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIVIDEND_W);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_LOAD;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	// The partial remainder always stays below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> rem_q < dsr_q)
		else $error("divider remainder not below divisor");

endmodule

// ===== rtl/core/joystick_pitch_tone_controller.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    joystick_sample, button_pressed
// out       output     out_valid / out_stall  tone_frequency, prescale_select, period_count,
//                                             duty_high_byte, duty_low_byte, button_debounced
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// A transaction runs through the microcode steps and the result register loads at the emit step;
// the next input can be taken in the cycle after. The shared restoring divider runs twice per
// transaction (prescale and period), each time with its start and wait steps, beside the six
// other microcode steps. The whole-hertz value comes from a reciprocal multiplication.
// Reset is asynchronous and active low; it restores the frequency, the press counter, the
// debouncer, both limit registers and the sequencer, and empties the output register.
// A stall on the output holds the result and freezes the sequencer at its emit step; the
// next input transaction is still taken while a finished result waits to be taken.
module joystick_pitch_tone_controller (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [jptc_pkg::SAMPLE_W-1:0]  joystick_sample,
	input  logic                           button_pressed,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [jptc_pkg::FREQ_W-1:0]    tone_frequency,
	output logic [jptc_pkg::PRE_W-1:0]     prescale_select,
	output logic [jptc_pkg::PERIOD_W-1:0]  period_count,
	output logic [jptc_pkg::DUTY_W-1:0]    duty_high_byte,
	output logic [jptc_pkg::DUTY_W-1:0]    duty_low_byte,
	output logic                           button_debounced,

	input  logic                           cfg_we,
	input  logic [jptc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jptc_pkg::FREQ_W-1:0]    cfg_data
);
	import jptc_pkg::*;

	localparam logic [PRESS_W-1:0] PRESS_MAX = 3'd6;
	localparam logic [PRESS_W-1:0] PRESS_ON  = 3'd4;
	localparam logic [PRESS_W-1:0] PRESS_OFF = 3'd2;

	typedef enum logic {
		DB_RELEASED,
		DB_PRESSED
	} db_state_t;

	// Control and architectural state.
	logic [STEP_W-1:0]  step_q;
	logic [FREQ_W-1:0]  floor_q;
	logic [FREQ_W-1:0]  ceil_q;
	logic [FREQ_W-1:0]  cur_q;
	logic [PRESS_W-1:0] press_q;
	db_state_t          db_q;
	logic               out_valid_q;

	// Datapath working registers.
	logic [SAMPLE_W-1:0]     sample_q;
	logic                    button_q;
	logic signed [INC_W-1:0] inc_q;
	logic [HZ_W-1:0]         hz_q;
	logic [PRE_W-1:0]        pre_q;

	// Output register.
	logic [FREQ_W-1:0]   freq_out_q;
	logic [PRE_W-1:0]    pre_out_q;
	logic [PERIOD_W-1:0] period_out_q;
	logic                db_out_q;

	ctl_word_t               cw;
	logic                    advance;
	logic                    out_take;
	logic signed [INC_W-1:0] inc_c;
	logic signed [FREQ_W+1:0] sum_c;
	logic [FREQ_W-1:0]       clamp_c;
	logic [PRESS_W-1:0]      press_next;
	db_state_t               db_next;
	logic [FREQ_W-HZ_SHIFT+RECIP_W-1:0] hz_prod;
	logic [HZ_W-1:0]         hz_c;
	logic [CLOCK_W-1:0]      p_c;
	logic [CLOCK_W-1:0]      pm1_c;
	logic [CLOCK_W-17:0]     k_c;
	logic [PRE_W-1:0]        pre_c;

	logic                    div_start;
	logic                    div_busy;
	logic [DIVIDEND_W-1:0]   div_a;
	logic [DIVISOR_W-1:0]    div_b;
	logic [DIVIDEND_W-1:0]   div_quo;

	// The control word for the current step comes straight from the program table.
	assign cw       = rom_word(step_q);
	assign out_take = out_valid_q & ~out_stall;
	assign in_stall = (cw.op != OP_TAKE);

	// Steps that wait: the input step waits for a transaction, the wait step holds while
	// the divider runs, and the emit step holds while the previous result is still stalled.
	always_comb begin
		case (cw.op)
			OP_TAKE:     advance = in_valid;
			OP_DIV_WAIT: advance = ~div_busy;
			OP_EMIT:     advance = ~out_valid_q | ~out_stall;
			default:     advance = 1'b1;
		endcase
	end

	// Signed increment: zone step times octave times 100, one multiplier.
	assign inc_c = zone_step(sample_q) * $signed({1'b0, octave_scale(cur_q)});

	// Clamp against the ceiling first, so the ceiling wins if the limits cross.
	always_comb begin
		sum_c = $signed({2'b00, cur_q}) + $signed({{(FREQ_W + 2 - INC_W){inc_q[INC_W-1]}}, inc_q});
		if (sum_c >= $signed({2'b00, ceil_q})) begin
			clamp_c = ceil_q;
		end else if (sum_c <= $signed({2'b00, floor_q})) begin
			clamp_c = floor_q;
		end else begin
			clamp_c = sum_c[FREQ_W-1:0];
		end
	end

	// Saturating press counter and the hysteresis debouncer on its new value.
	always_comb begin
		press_next = press_q;
		if (button_q) begin
			if (press_q < PRESS_MAX) press_next = press_q + 1'b1;
		end else begin
			if (press_q != '0) press_next = press_q - 1'b1;
		end
		db_next = db_q;
		case (db_q)
			DB_RELEASED: if (press_next > PRESS_ON) db_next = DB_PRESSED;
			DB_PRESSED:  if (press_next < PRESS_OFF) db_next = DB_RELEASED;
			default:     db_next = DB_RELEASED;
		endcase
	end

	// Whole hertz of the new frequency by reciprocal multiplication.
	assign hz_prod = cur_q[FREQ_W-1:HZ_SHIFT] * HZ_RECIP;
	assign hz_c    = hz_prod[RECIP_SHIFT +: HZ_W];

	// Prescaler: (p - 1) / 65536, limited to seven.
	always_comb begin
		p_c   = div_quo;
		pm1_c = p_c - 1'b1;
		k_c   = (p_c == '0) ? '0 : pm1_c[CLOCK_W-1:16];
		pre_c = (|k_c[CLOCK_W-17:PRE_W]) ? {PRE_W{1'b1}} : k_c[PRE_W-1:0];
	end

	// Divider operand selection.
	assign div_start = (cw.op == OP_DIV_GO);
	assign div_b     = hz_q;

	always_comb begin
		case (cw.a_sel)
			A_CLOCK:   div_a = CLOCK_HZ;
			A_SHIFTED: div_a = CLOCK_HZ >> pre_q;
			default:   div_a = CLOCK_HZ;
		endcase
	end

	jptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Sequencer, configuration registers and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			floor_q     <= FLOOR_RESET;
			ceil_q      <= CEIL_RESET;
			cur_q       <= FREQ_RESET;
			press_q     <= '0;
			db_q        <= DB_RELEASED;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FREQ_FLOOR:   floor_q <= cfg_data;
					REG_FREQ_CEILING: ceil_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				step_q <= cw.jump ? cw.target : step_q + 1'b1;
			end
			case (cw.op)
				OP_STEP: begin
					press_q <= press_next;
					db_q    <= db_next;
				end
				OP_CLAMP: cur_q <= clamp_c;
				OP_EMIT:  if (advance) out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Datapath and output payload registers.
	always_ff @(posedge clk) begin
		case (cw.op)
			OP_TAKE: begin
				if (in_valid) begin
					sample_q <= joystick_sample;
					button_q <= button_pressed;
				end
			end
			OP_STEP: inc_q <= inc_c;
			OP_HZ:   hz_q  <= (hz_c == '0) ? HZ_W'(1) : hz_c;
			OP_PRE:  pre_q <= pre_c;
			OP_EMIT: begin
				if (advance) begin
					freq_out_q   <= cur_q;
					pre_out_q    <= pre_q;
					period_out_q <= div_quo[PERIOD_W-1:0];
					db_out_q     <= (db_q == DB_PRESSED);
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign tone_frequency   = freq_out_q;
	assign prescale_select  = pre_out_q;
	assign period_count     = period_out_q;
	assign duty_high_byte   = period_out_q[PERIOD_W-1:PERIOD_W-DUTY_W];
	assign duty_low_byte    = period_out_q[DUTY_W:1];
	assign button_debounced = db_out_q;

	// The divider only runs while the program sits on a wait step.
	assert property (@(posedge clk) disable iff (!arst_n) div_busy |-> cw.op == OP_DIV_WAIT)
		else $error("divider busy outside a wait step");

	// A new result appears only out of the emit step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cw.op == OP_EMIT))
		else $error("result raised outside the emit step");

	// The debouncer reports pressed only once the counter has passed its threshold.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(db_q == DB_PRESSED) |-> press_q > PRESS_ON)
		else $error("debouncer pressed below threshold");

	// The press counter saturates.
	assert property (@(posedge clk) disable iff (!arst_n) press_q <= PRESS_MAX)
		else $error("press counter out of range");

endmodule

// ===== test/joystick_pitch_tone_controller_test.sv =====
`timescale 1ns / 1ps

module joystick_pitch_tone_controller_test;

	import jptc_pkg::FREQ_W;
	import jptc_pkg::SAMPLE_W;
	import jptc_pkg::PRE_W;
	import jptc_pkg::PERIOD_W;
	import jptc_pkg::DUTY_W;
	import jptc_pkg::CFG_IDX_W;

	// Fixed figures of the tone arithmetic, kept here so that the arithmetic of the expected values
	// does not lean on the design's own constants.
	localparam int unsigned HZ_DIV      = 100000;
	localparam int unsigned PWM_CLOCK   = 24000000;
	localparam int unsigned PERIOD_SPAN = 65536;
	localparam int unsigned PRESS_MAX   = 6;
	localparam logic [FREQ_W-1:0] FREQ_TOP   = '1;
	localparam logic [FREQ_W-1:0] START_FREQ = 29'd250000000;

	// A million cycles is several times the slowest correct run of the whole test, idling and
	// the long hold-off included.
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 600;
	localparam int TAIL_CYCLES   = 150;
	localparam int IDLE_PERCENT  = 23;

	// Joystick edges: both ends, the center, and both sides of every zone threshold.
	localparam logic [0:22][7:0] EDGE_SAMPLES = {
		8'd255, 8'd238, 8'd237, 8'd218, 8'd217, 8'd198, 8'd197, 8'd178,
		8'd177, 8'd158, 8'd157, 8'd128, 8'd98,  8'd97,  8'd78,  8'd77,
		8'd58,  8'd57,  8'd38,  8'd37,  8'd18,  8'd17,  8'd0
	};
	// Seven presses saturate the counter and latch the debouncer, five releases bring
	// it back down to the release threshold, and the rest wiggles and then settles.
	localparam logic [0:22] PRESS_PATTERN = 23'b1111111_00000_10110000000;

	typedef enum logic [1:0] {
		DRIFT_NONE,
		DRIFT_UP,
		DRIFT_DOWN
	} drift_t;

	typedef enum logic [1:0] {
		SWEEP_UP,
		SWEEP_DOWN,
		SWEEP_ANY,
		SWEEP_REST
	} sweep_t;

	typedef struct packed {
		logic [FREQ_W-1:0]   freq;
		logic [PRE_W-1:0]    pre;
		logic [PERIOD_W-1:0] period;
		logic [DUTY_W-1:0]   duty_hi;
		logic [DUTY_W-1:0]   duty_lo;
		logic                held;
	} tone_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid        = 1'b0;
	logic                 in_stall;
	logic [SAMPLE_W-1:0]  joystick_sample = '0;
	logic                 button_pressed  = 1'b0;

	logic                 out_valid;
	logic                 out_stall       = 1'b0;
	logic [FREQ_W-1:0]    tone_frequency;
	logic [PRE_W-1:0]     prescale_select;
	logic [PERIOD_W-1:0]  period_count;
	logic [DUTY_W-1:0]    duty_high_byte;
	logic [DUTY_W-1:0]    duty_low_byte;
	logic                 button_debounced;

	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = jptc_pkg::REG_FREQ_FLOOR;
	logic [FREQ_W-1:0]    cfg_data  = '0;

	// Our own copy of the tone state and of the two limit registers.
	logic [FREQ_W-1:0] freq_now;
	logic [FREQ_W-1:0] floor_now;
	logic [FREQ_W-1:0] ceiling_now;
	int unsigned       press_level;
	logic              button_held;

	// Tones that have been predicted but not yet seen on the output, oldest first.
	tone_result_t pending_tones[$];

	// Shared knobs: quiet turns all idling off on both sides, hold_request asks the
	// receiver for one long hold-off.
	bit quiet        = 1'b0;
	bit hold_request = 1'b0;
	int hold_left    = 0;

	int cycle_count       = 0;
	int mismatches        = 0;
	int items_sent        = 0;
	int tones_checked     = 0;
	int limit_settings    = 0;
	int backpressure_seen = 0;

	joystick_pitch_tone_controller u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.joystick_sample  (joystick_sample),
		.button_pressed   (button_pressed),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.tone_frequency   (tone_frequency),
		.prescale_select  (prescale_select),
		.period_count     (period_count),
		.duty_high_byte   (duty_high_byte),
		.duty_low_byte    (duty_low_byte),
		.button_debounced (button_debounced),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Works out the tone that one joystick transaction should produce and moves the
	// predicted state along. The octave comes from the frequency before the step.
	function automatic tone_result_t next_tone(input logic [SAMPLE_W-1:0] sample,
			input logic level);
		tone_result_t      r;
		int                offset;
		int                step_size;
		int                octave;
		int unsigned       whole_hz;
		int unsigned       ticks;
		int unsigned       prescale;
		longint            target;
		logic [FREQ_W-1:0] f;

		offset = int'(sample) - 128;
		if (offset >= 110)       step_size = 5000;
		else if (offset >= 90)   step_size = 2500;
		else if (offset >= 70)   step_size = 1250;
		else if (offset >= 50)   step_size = 625;
		else if (offset >= 30)   step_size = 300;
		else if (offset >= -30)  step_size = 0;
		else if (offset >= -50)  step_size = -300;
		else if (offset >= -70)  step_size = -625;
		else if (offset >= -90)  step_size = -1250;
		else if (offset >= -110) step_size = -2500;
		else                     step_size = -5000;

		whole_hz = 32'(freq_now);
		whole_hz = whole_hz / HZ_DIV;
		if (whole_hz > 4100)      octave = 8;
		else if (whole_hz > 2070) octave = 7;
		else if (whole_hz > 1040) octave = 6;
		else if (whole_hz > 520)  octave = 5;
		else if (whole_hz > 260)  octave = 4;
		else if (whole_hz > 130)  octave = 3;
		else if (whole_hz > 80)   octave = 2;
		else                      octave = 0;

		// The ceiling is tested first, so it wins when the limits are crossed.
		target = longint'(freq_now) + longint'(step_size) * octave * 100;
		if (target >= longint'(ceiling_now))    f = ceiling_now;
		else if (target <= longint'(floor_now)) f = floor_now;
		else                                    f = target[FREQ_W-1:0];

		// Below one hertz the divisor is pinned to one.
		whole_hz = 32'(f);
		whole_hz = whole_hz / HZ_DIV;
		if (whole_hz == 0)
			whole_hz = 1;
		ticks    = PWM_CLOCK / whole_hz;
		prescale = (ticks == 0) ? 0 : (ticks - 1) / PERIOD_SPAN;
		if (prescale > 7)
			prescale = 7;
		// Only the low sixteen bits of the period survive, larger values wrap.
		ticks = (PWM_CLOCK >> prescale) / whole_hz;

		if (level) begin
			if (press_level < PRESS_MAX)
				press_level++;
		end else begin
			if (press_level > 0)
				press_level--;
		end
		if (!button_held) begin
			if (press_level > 4)
				button_held = 1'b1;
		end else begin
			if (press_level < 2)
				button_held = 1'b0;
		end

		freq_now  = f;
		r.freq    = f;
		r.pre     = prescale[PRE_W-1:0];
		r.period  = ticks[PERIOD_W-1:0];
		r.duty_hi = r.period[15:9];
		r.duty_lo = r.period[7:1];
		r.held    = button_held;
		return r;
	endfunction

	// Offers one joystick transaction. It is entered at a falling edge and returns at
	// the falling edge after acceptance, leaving valid high so that the next call can
	// keep streaming; a random number of idle cycles may come first.
	task automatic send_item(input logic [SAMPLE_W-1:0] sample, input logic level);
		while (!quiet && $urandom_range(99, 0) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		joystick_sample <= sample;
		button_pressed  <= level;
		do
			@(posedge clk);
		while (in_stall);
		pending_tones.push_back(next_tone(sample, level));
		items_sent++;
		@(negedge clk);
	endtask

	// Drops valid and waits until every predicted tone has come out. Every transaction
	// yields exactly one tone, so an empty queue means the block is idle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_tones.size() != 0)
			@(negedge clk);
	endtask

	// Waits until the block is idle, then writes both limit registers back to back.
	task automatic set_limits(input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] hi);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= jptc_pkg::REG_FREQ_FLOOR;
		cfg_data  <= lo;
		@(negedge clk);
		cfg_index <= jptc_pkg::REG_FREQ_CEILING;
		cfg_data  <= hi;
		@(negedge clk);
		cfg_we      <= 1'b0;
		floor_now   = lo;
		ceiling_now = hi;
		limit_settings++;
	endtask

	// Random stream made of bursts. Each burst pushes the joystick one way, wanders,
	// or rests near the center, so that the frequency sweeps through whole octaves and
	// runs into the limits. The button comes in held levels with a little chatter.
	task automatic run_random(input int count, input drift_t drift);
		int                  burst_left;
		int                  level_left;
		int                  pick;
		int                  k;
		sweep_t              sweep;
		logic [SAMPLE_W-1:0] sample;
		logic                level;

		burst_left = 0;
		level_left = 0;
		level      = 1'b0;
		sweep      = SWEEP_ANY;
		for (k = 0; k < count; k++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 4);
				pick       = $urandom_range(99, 0);
				case (drift)
					DRIFT_UP: begin
						sweep = (pick < 60) ? SWEEP_UP : (pick < 75) ? SWEEP_DOWN :
							(pick < 90) ? SWEEP_ANY : SWEEP_REST;
					end
					DRIFT_DOWN: begin
						sweep = (pick < 60) ? SWEEP_DOWN : (pick < 75) ? SWEEP_UP :
							(pick < 90) ? SWEEP_ANY : SWEEP_REST;
					end
					default: begin
						sweep = (pick < 30) ? SWEEP_UP : (pick < 60) ? SWEEP_DOWN :
							(pick < 85) ? SWEEP_ANY : SWEEP_REST;
					end
				endcase
			end
			burst_left--;
			case (sweep)
				SWEEP_UP:   sample = SAMPLE_W'($urandom_range(255, 158));
				SWEEP_DOWN: sample = SAMPLE_W'($urandom_range(97, 0));
				SWEEP_REST: sample = SAMPLE_W'($urandom_range(157, 98));
				default:    sample = SAMPLE_W'($urandom_range(255, 0));
			endcase
			if (level_left == 0) begin
				level      = 1'($urandom_range(1, 0));
				level_left = $urandom_range(9, 1);
			end
			level_left--;
			send_item(sample, ($urandom_range(9, 0) == 0) ? !level : level);
		end
	endtask

	// Directed pass with the reset limits: every zone edge and the debouncer's full
	// press, latch, release and saturation cycle.
	task automatic test_zone_edges();
		int k;

		for (k = 0; k < 23; k++)
			send_item(EDGE_SAMPLES[k], PRESS_PATTERN[k]);
	endtask

	// Reset limits again, first with no idling at all, then with the long hold-off on
	// the output while the input keeps offering transactions.
	task automatic test_default_sweeps();
		quiet = 1'b1;
		run_random(100, DRIFT_NONE);
		quiet        = 1'b0;
		hold_request = 1'b1;
		run_random(300, DRIFT_NONE);
	endtask

	// The widest limits: the frequency climbs to the all-ones ceiling, then sinks until
	// the octave drops to zero and the step vanishes.
	task automatic test_full_range();
		set_limits('0, FREQ_TOP);
		run_random(150, DRIFT_UP);
		run_random(150, DRIFT_DOWN);
	endtask

	// Floor above the ceiling, so the ceiling test has to win.
	task automatic test_inverted_limits();
		set_limits(29'd300000000, 29'd200000000);
		run_random(100, DRIFT_NONE);
	endtask

	// Limits pinned together at a mid value, at zero (the sub-hertz divisor case) and at all ones, plus a sub-hertz band.
	task automatic test_pinned_limits();
		set_limits(29'd123456789, 29'd123456789);
		run_random(60, DRIFT_NONE);
		set_limits('0, '0);
		run_random(30, DRIFT_NONE);
		set_limits(29'd40000, 29'd99999);
		run_random(30, DRIFT_NONE);
		set_limits(FREQ_TOP, FREQ_TOP);
		run_random(30, DRIFT_NONE);
	endtask

	// A narrow band straddling the lowest octave boundary.
	task automatic test_octave_edge();
		set_limits(29'd8000000, 29'd9000000);
		run_random(100, DRIFT_NONE);
	endtask

	// Random limit pairs, mostly ordered, the last one crossed.
	task automatic test_random_limits();
		logic [FREQ_W-1:0] lo;
		logic [FREQ_W-1:0] hi;
		int                k;

		for (k = 0; k < 5; k++) begin
			lo = FREQ_W'($urandom_range(400000000, 0));
			hi = (k == 4) ? FREQ_W'($urandom_range(int'(lo), 0)) :
				FREQ_W'($urandom_range(int'(FREQ_TOP), int'(lo)));
			set_limits(lo, hi);
			run_random(80, DRIFT_NONE);
		end
	endtask

	// Back to the reset values written explicitly.
	task automatic test_reset_limits();
		set_limits(jptc_pkg::FLOOR_RESET, jptc_pkg::CEIL_RESET);
		run_random(300, DRIFT_NONE);
	endtask

	// Receiver: stalls at random on the falling edge, or holds off for a long counted
	// stretch when asked, so that the block fills up and pushes back on its input.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
				if (in_valid && in_stall)
					backpressure_seen++;
			end else begin
				out_stall <= !quiet && ($urandom_range(99, 0) < IDLE_PERCENT);
			end
		end
	end

	// Checker: each tone taken from the output is compared with the oldest prediction.
	always @(posedge clk) begin
		tone_result_t want;

		if (arst_n && out_valid && !out_stall) begin
			if (pending_tones.size() == 0) begin
				$error("tone result with no transaction waiting: frequency %0d", tone_frequency);
				mismatches++;
			end else begin
				want = pending_tones.pop_front();
				tones_checked++;
				if (tone_frequency !== want.freq) begin
					$error("tone_frequency: expected %0d, got %0d", want.freq, tone_frequency);
					mismatches++;
				end
				if (prescale_select !== want.pre) begin
					$error("prescale_select: expected %0d, got %0d", want.pre, prescale_select);
					mismatches++;
				end
				if (period_count !== want.period) begin
					$error("period_count: expected %0d, got %0d", want.period, period_count);
					mismatches++;
				end
				if (duty_high_byte !== want.duty_hi) begin
					$error("duty_high_byte: expected %0d, got %0d", want.duty_hi, duty_high_byte);
					mismatches++;
				end
				if (duty_low_byte !== want.duty_lo) begin
					$error("duty_low_byte: expected %0d, got %0d", want.duty_lo, duty_low_byte);
					mismatches++;
				end
				if (button_debounced !== want.held) begin
					$error("button_debounced: expected %0d, got %0d", want.held, button_debounced);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a run that hangs anywhere ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("joystick_pitch_tone_controller_test: done, errors");
		$finish;
	end

	initial begin
		// The predicted state starts where the block's reset leaves it.
		freq_now    = START_FREQ;
		floor_now   = jptc_pkg::FLOOR_RESET;
		ceiling_now = jptc_pkg::CEIL_RESET;
		press_level = 0;
		button_held = 1'b0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_zone_edges();
		test_default_sweeps();
		test_full_range();
		test_inverted_limits();
		test_pinned_limits();
		test_octave_edge();
		test_random_limits();
		test_reset_limits();

		// Let everything drain, then give the block a little longer in case it
		// produces something nobody asked for.
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d tones from %0d joystick transactions over %0d limit settings.",
			tones_checked, items_sent, limit_settings);
		$display("The long output hold-off kept the input stalled for %0d cycles.",
			backpressure_seen);
		if (mismatches == 0 && pending_tones.size() == 0) begin
			$display("joystick_pitch_tone_controller_test: done, clean");
		end else begin
			$display("joystick_pitch_tone_controller_test: done, errors");
		end
		$finish;
	end

endmodule

// ===== joystick_pitch_tone_controller.f =====
rtl/core/jptc_pkg.sv
rtl/core/jptc_div.sv
rtl/core/joystick_pitch_tone_controller.sv
test/joystick_pitch_tone_controller_test.sv
